// ===== sv/multi_queue_shared_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer assertion macros
// Concurrent assertion helpers shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MQSB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQSB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer package
// Sizes, pointer encoding, status codes and controller states.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int SLOTS      = 64;
    localparam int QUEUES     = 8;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = SLOT_W + 1;
    localparam int QID_W  = 3;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 32;

    // The null pointer is the value SLOTS.
    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(SLOTS);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_HOLD
    } state_t;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

// ===== sv/multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// Multi-queue shared buffer
// Several FIFO queues threaded as linked lists through one shared slot store.
// ----------------------------------------------------------------------------
// The input stream carries one request per beat: s_tuser holds the operation
// (enqueue or dequeue) and the queue number, s_tdata the word to enqueue.
// Every request gives exactly one response on the output stream: m_tuser is
// the status (ok, buffer full, queue empty) and m_tdata the dequeued word,
// zero for enqueues and failed requests.
// A request is taken only while the controller is idle. A rejected request
// is answered from the idle state; a dequeue or an enqueue to an empty queue
// finishes in the execute state, and an enqueue to a non-empty queue goes on
// to a link state for the second write through the link memory's one write
// port. The data and link memories are read into registers on acceptance.
// The response sits in an output register, so the next request is taken while
// a response waits; if the receiver still holds the previous one when a new
// response is due, the controller waits with it until the register frees.
// Reset empties every queue and puts all slots on the free list at once; the
// link memory keeps a valid bit per entry, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_defines.svh"

module multi_queue_shared_buffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value[31:0]
    input  logic [3:0]  s_tuser,   // op[0], queue_id[3:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pop_value[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int SLOTS  = mqsb_pkg::SLOTS;
    localparam int QUEUES = mqsb_pkg::QUEUES;
    localparam int DW     = mqsb_pkg::DATA_WIDTH;
    localparam int SLOT_W = mqsb_pkg::SLOT_W;
    localparam int PTR_W  = mqsb_pkg::PTR_W;
    localparam int QID_W  = mqsb_pkg::QID_W;
    localparam int OUT_W  = mqsb_pkg::OUT_W;

    mqsb_pkg::state_t state_reg, state_next;

    logic             op_reg, op_next;
    logic [QID_W-1:0] qid_reg, qid_next;
    logic [DW-1:0]    val_reg, val_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [PTR_W-1:0] head_reg [QUEUES];
    logic [PTR_W-1:0] tail_reg [QUEUES];
    logic             head_we, tail_we;
    logic [PTR_W-1:0] head_wdata, tail_wdata;

    logic [DW-1:0]    data_mem [SLOTS];
    logic [PTR_W-1:0] link_mem [SLOTS];
    logic             link_vld_reg [SLOTS];
    logic [DW-1:0]    data_rd_reg;
    logic [PTR_W-1:0] link_rd_reg;
    logic             link_vld_rd_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              data_we;
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [PTR_W-1:0]  link_wdata;

    mqsb_pkg::status_t res_status_reg, res_status_next, res_status;
    logic [OUT_W-1:0]  res_pop_reg, res_pop_next, res_pop;
    logic              res_valid;

    logic              m_tvalid_reg, m_tvalid_next;
    mqsb_pkg::status_t m_status_reg, m_status_next;
    logic [OUT_W-1:0]  m_pop_reg, m_pop_next;

    logic             in_op;
    logic [QID_W-1:0] in_qid;
    logic             qid_ok;
    logic [PTR_W-1:0] in_ptr;
    logic [PTR_W-1:0] link_val;
    logic             out_free;
    logic             accept;
    logic             sel_head_null, sel_tail_null;

    assign in_op    = s_tuser[0];
    assign in_qid   = s_tuser[3:1];
    assign qid_ok   = ((QID_W + 1)'(in_qid) < (QID_W + 1)'(QUEUES));
    assign in_ptr   = (in_op == mqsb_pkg::OP_DEQ) ? head_reg[in_qid] : free_head_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == mqsb_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // An entry never written still holds its reset link to the next slot.
    assign link_val = link_vld_rd_reg ? link_rd_reg : (PTR_W'(slot_reg) + PTR_W'(1));

    assign sel_head_null = (head_reg[in_qid] >= PTR_W'(SLOTS));
    assign sel_tail_null = (tail_reg[in_qid] >= PTR_W'(SLOTS));

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        qid_next        = qid_reg;
        val_next        = val_reg;
        slot_next       = slot_reg;
        free_head_next  = free_head_reg;
        head_we         = 1'b0;
        tail_we         = 1'b0;
        head_wdata      = mqsb_pkg::PTR_NULL;
        tail_wdata      = mqsb_pkg::PTR_NULL;
        rd_en           = 1'b0;
        rd_addr         = in_ptr[SLOT_W-1:0];
        data_we         = 1'b0;
        link_we         = 1'b0;
        link_waddr      = slot_reg;
        link_wdata      = mqsb_pkg::PTR_NULL;
        res_valid       = 1'b0;
        res_status      = mqsb_pkg::STAT_OK;
        res_pop         = '0;
        res_status_next = res_status_reg;
        res_pop_next    = res_pop_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_pop_next      = m_pop_reg;

        case (state_reg)
            mqsb_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next   = in_op;
                    qid_next  = in_qid;
                    val_next  = s_tdata[DW-1:0];
                    slot_next = in_ptr[SLOT_W-1:0];
                    if (!qid_ok || (in_ptr >= PTR_W'(SLOTS))) begin
                        res_valid  = 1'b1;
                        res_status = (in_op == mqsb_pkg::OP_DEQ) ? mqsb_pkg::STAT_EMPTY
                                                                 : mqsb_pkg::STAT_FULL;
                    end else begin
                        rd_en      = 1'b1;
                        state_next = mqsb_pkg::ST_EXEC;
                    end
                end
            end
            mqsb_pkg::ST_EXEC: begin
                if (op_reg == mqsb_pkg::OP_ENQ) begin
                    free_head_next = link_val;
                    data_we        = 1'b1;
                    link_we        = 1'b1;
                    link_waddr     = slot_reg;
                    link_wdata     = mqsb_pkg::PTR_NULL;
                    if (head_reg[qid_reg] >= PTR_W'(SLOTS)) begin
                        head_we    = 1'b1;
                        head_wdata = PTR_W'(slot_reg);
                        tail_we    = 1'b1;
                        tail_wdata = PTR_W'(slot_reg);
                        res_valid  = 1'b1;
                    end else begin
                        state_next = mqsb_pkg::ST_LINK;
                    end
                end else begin
                    res_valid  = 1'b1;
                    res_pop    = OUT_W'(data_rd_reg);
                    head_we    = 1'b1;
                    if (link_val >= PTR_W'(SLOTS)) begin
                        head_wdata = mqsb_pkg::PTR_NULL;
                        tail_we    = 1'b1;
                        tail_wdata = mqsb_pkg::PTR_NULL;
                    end else begin
                        head_wdata = link_val;
                    end
                    link_we        = 1'b1;
                    link_waddr     = slot_reg;
                    link_wdata     = free_head_reg;
                    free_head_next = PTR_W'(slot_reg);
                end
            end
            mqsb_pkg::ST_LINK: begin
                link_we    = 1'b1;
                link_waddr = tail_reg[qid_reg][SLOT_W-1:0];
                link_wdata = PTR_W'(slot_reg);
                tail_we    = 1'b1;
                tail_wdata = PTR_W'(slot_reg);
                res_valid  = 1'b1;
            end
            mqsb_pkg::ST_HOLD: begin
                res_valid  = 1'b1;
                res_status = res_status_reg;
                res_pop    = res_pop_reg;
            end
            default: begin
                state_next = mqsb_pkg::ST_IDLE;
            end
        endcase

        if (res_valid) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_status_next = res_status;
                m_pop_next    = res_pop;
                state_next    = mqsb_pkg::ST_IDLE;
            end else begin
                res_status_next = res_status;
                res_pop_next    = res_pop;
                state_next      = mqsb_pkg::ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mqsb_pkg::ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            free_head_reg <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                head_reg[i] <= mqsb_pkg::PTR_NULL;
                tail_reg[i] <= mqsb_pkg::PTR_NULL;
            end
            for (int i = 0; i < SLOTS; i++) begin
                link_vld_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            free_head_reg <= free_head_next;
            if (head_we) begin
                head_reg[qid_reg] <= head_wdata;
            end
            if (tail_we) begin
                tail_reg[qid_reg] <= tail_wdata;
            end
            if (link_we) begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        qid_reg        <= qid_next;
        val_reg        <= val_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_pop_reg    <= res_pop_next;
        m_status_reg   <= m_status_next;
        m_pop_reg      <= m_pop_next;
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[slot_reg] <= val_reg;
        end
        if (rd_en) begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en) begin
            link_rd_reg     <= link_mem[rd_addr];
            link_vld_rd_reg <= link_vld_reg[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pop_reg;
    assign m_tuser  = m_status_reg;

    `MQSB_ASSERT_IMP(a_head_tail_agree, aclk, aresetn, state_reg == mqsb_pkg::ST_IDLE, sel_head_null == sel_tail_null, "Queue head and tail disagree on emptiness.")
    `MQSB_ASSERT_NXT(a_free_head_moves, aclk, aresetn, (state_reg == mqsb_pkg::ST_EXEC) && (op_reg == mqsb_pkg::OP_ENQ), free_head_reg != $past(free_head_reg), "Free list head did not advance on enqueue.")
    `MQSB_ASSERT_IMP(a_write_states, aclk, aresetn, link_we || data_we, (state_reg == mqsb_pkg::ST_EXEC) || (state_reg == mqsb_pkg::ST_LINK), "Memory written outside an execute state.")

endmodule
